@@ src/stid_pkg.sv @@
// Shared types, codes and widths for the string-table image deframer.
package stid_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned POS_W    = 3;

    localparam logic [WORD_W-1:0] MAGIC_RESET = 32'h4C52_5453;

    // Parser phases.
    localparam logic [PHASE_W-1:0] PH_MAGIC   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FAULT   = 3'd5;

    // Status codes reported with every item.
    localparam logic [STATUS_W-1:0] ST_RUN       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VALID     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRAIL     = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] image_byte;
        logic              last_byte;
    } stid_in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic                is_payload;
        logic [WORD_W-1:0]   record_index;
        logic                record_end;
        logic [WORD_W-1:0]   records_done;
        logic [STATUS_W-1:0] status;
    } stid_result_t;

endpackage

@@ src/string_table_image_deframer.sv @@
// Top level of the string-table image deframer.
//
// The image arrives one byte per item on the in channel (image_byte, with
// last_byte on the final byte). Every input item yields exactly one output
// item: the byte passed through as data_byte, labelled with is_payload,
// record_index, record_end, records_done and a status code.
// The cfg channel writes expected_magic; it is always ready and should only
// be written while no bytes are in flight.
// A byte accepted into the input register is worked on there by the parse
// logic, and its output item is then loaded into the result register.
// Throughput is one byte per cycle while out_ready holds, limited by the
// parser state update (a 32-bit count increment and compare per byte).
// When the receiver stalls, the result register and the input register each
// hold one item, so in_ready drops only once both are full.
// Reset clears both registers, returns the parser to the magic word and
// loads expected_magic with its default. The last byte of each image also
// returns the parser to its start, so images may follow back to back.
module string_table_image_deframer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stid_pkg::WORD_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [stid_pkg::BYTE_W-1:0]        image_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [stid_pkg::BYTE_W-1:0]        data_byte,
    output logic                               is_payload,
    output logic [stid_pkg::WORD_W-1:0]        record_index,
    output logic                               record_end,
    output logic [stid_pkg::WORD_W-1:0]        records_done,
    output logic [stid_pkg::STATUS_W-1:0]      status
);
    import stid_pkg::*;

    logic [WORD_W-1:0] magic_reg;
    stid_in_item_t     in_item;
    stid_in_item_t     held_item;
    logic              held_valid;
    logic              can_load;
    logic              step;
    stid_result_t      core_result;
    stid_result_t      out_result;

    // The magic register accepts a write on any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= MAGIC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            magic_reg <= cfg_data;
        end
    end

    assign in_item.image_byte = image_byte;
    assign in_item.last_byte  = last_byte;

    // A held byte is parsed whenever the result register has room for it.
    assign step = held_valid && can_load;

    stid_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    stid_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .item           (held_item),
        .expected_magic (magic_reg),
        .result         (core_result)
    );

    stid_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .result      (core_result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .held_result (out_result)
    );

    assign data_byte    = out_result.data_byte;
    assign is_payload   = out_result.is_payload;
    assign record_index = out_result.record_index;
    assign record_end   = out_result.record_end;
    assign records_done = out_result.records_done;
    assign status       = out_result.status;

endmodule

@@ src/stid_in_stage.sv @@
// Input register of the deframer: holds one accepted byte until it is parsed.
module stid_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  stid_pkg::stid_in_item_t in_item,
    input  logic                   take,
    output logic                   held_valid,
    output stid_pkg::stid_in_item_t held_item
);
    import stid_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    stid_in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ src/stid_core.sv @@
// Parser state and the per-byte next-state and labelling logic.
module stid_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  stid_pkg::stid_in_item_t           item,
    input  logic [stid_pkg::WORD_W-1:0]       expected_magic,
    output stid_pkg::stid_result_t            result
);
    import stid_pkg::*;

    logic [PHASE_W-1:0]  phase_reg,   phase_next;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [WORD_W-1:0]   shift_reg,   shift_next;
    logic                high_nz_reg, high_nz_next;
    logic [WORD_W-1:0]   total_reg,   total_next;
    logic [WORD_W-1:0]   fin_reg,     fin_next;
    logic [WORD_W-1:0]   left_reg,    left_next;
    logic [STATUS_W-1:0] fault_reg,   fault_next;

    logic [WORD_W-1:0]   shifted;
    logic [POS_W-1:0]    pos_inc;
    logic [WORD_W-1:0]   fin_inc;
    logic [WORD_W-1:0]   left_dec;
    logic                high_nz_now;
    logic                pay;
    logic [WORD_W-1:0]   idx;
    logic                rec_end;
    logic [STATUS_W-1:0] status;

    always_comb
    begin
        shifted     = shift_reg | ({{(WORD_W-BYTE_W){1'b0}}, item.image_byte}
                                   << {pos_reg[1:0], 3'b000});
        pos_inc     = pos_reg + 3'd1;
        fin_inc     = fin_reg + 32'd1;
        left_dec    = left_reg - 32'd1;
        high_nz_now = high_nz_reg;

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        high_nz_next = high_nz_reg;
        total_next   = total_reg;
        fin_next     = fin_reg;
        left_next    = left_reg;
        fault_next   = fault_reg;

        pay     = 1'b0;
        idx     = '0;
        rec_end = 1'b0;
        status  = ST_RUN;

        case (phase_reg)
            PH_MAGIC:
            begin
                shift_next = shifted;
                pos_next   = pos_inc;
                if (item.last_byte)
                begin
                    phase_next = PH_FAULT;
                    fault_next = ST_TRUNC;
                end
                else if (pos_inc == 3'd4)
                begin
                    if (shifted != expected_magic)
                    begin
                        phase_next = PH_FAULT;
                        fault_next = ST_BAD_MAGIC;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        pos_next   = '0;
                        shift_next = '0;
                    end
                end
            end
            PH_COUNT:
            begin
                // Low four bytes build the count; high four must all be zero.
                if (!pos_reg[2])
                begin
                    shift_next = shifted;
                end
                else
                begin
                    high_nz_now = high_nz_reg || (item.image_byte != 8'd0);
                end
                high_nz_next = high_nz_now;
                pos_next     = pos_inc;
                if (pos_inc == 3'd0)
                begin
                    if (high_nz_now)
                    begin
                        phase_next = PH_FAULT;
                        fault_next = ST_BAD_COUNT;
                    end
                    else
                    begin
                        total_next = shift_reg;
                        shift_next = '0;
                        phase_next = (shift_reg == '0) ? PH_DONE : PH_LEN;
                    end
                end
                else if (item.last_byte)
                begin
                    phase_next = PH_FAULT;
                    fault_next = ST_TRUNC;
                end
            end
            PH_LEN:
            begin
                idx        = fin_reg;
                shift_next = shifted;
                pos_next   = pos_inc;
                if (pos_inc == 3'd4)
                begin
                    pos_next   = '0;
                    left_next  = shifted;
                    shift_next = '0;
                    if (shifted == '0)
                    begin
                        // An empty record closes on its last length byte.
                        rec_end    = 1'b1;
                        fin_next   = fin_inc;
                        phase_next = (fin_inc == total_reg) ? PH_DONE : PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                pay       = 1'b1;
                idx       = fin_reg;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    rec_end    = 1'b1;
                    fin_next   = fin_inc;
                    phase_next = (fin_inc == total_reg) ? PH_DONE : PH_LEN;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_FAULT;
                fault_next = ST_TRAIL;
            end
            default:
            begin
                // Faulted: bytes pass through with the fault code until the end of the image.
            end
        endcase

        if (phase_next == PH_FAULT)
        begin
            status  = fault_next;
            pay     = 1'b0;
            idx     = '0;
            rec_end = 1'b0;
        end
        else if (item.last_byte)
        begin
            status = (phase_next == PH_DONE) ? ST_VALID : ST_TRUNC;
        end

        result.data_byte    = item.image_byte;
        result.is_payload   = pay;
        result.record_index = idx;
        result.record_end   = rec_end;
        result.records_done = fin_next;
        result.status       = status;

        // The last byte of an image returns the parser to its start.
        if (item.last_byte)
        begin
            phase_next   = PH_MAGIC;
            pos_next     = '0;
            shift_next   = '0;
            high_nz_next = 1'b0;
            total_next   = '0;
            fin_next     = '0;
            left_next    = '0;
            fault_next   = ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC;
            pos_reg     <= '0;
            shift_reg   <= '0;
            high_nz_reg <= 1'b0;
            total_reg   <= '0;
            fin_reg     <= '0;
            left_reg    <= '0;
            fault_reg   <= ST_RUN;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            shift_reg   <= shift_next;
            high_nz_reg <= high_nz_next;
            total_reg   <= total_next;
            fin_reg     <= fin_next;
            left_reg    <= left_next;
            fault_reg   <= fault_next;
        end
    end

endmodule

@@ src/stid_out_stage.sv @@
// Result register of the deframer: holds one labelled byte until it is taken.
module stid_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  stid_pkg::stid_result_t result,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output stid_pkg::stid_result_t held_result
);
    import stid_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    stid_result_t result_reg;

    assign can_load    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign held_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ src/stid_checker.sv @@
// Port-level assertions for the string-table image deframer, bound to the top.
module stid_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [stid_pkg::BYTE_W-1:0]        image_byte,
    input  logic                               last_byte,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [stid_pkg::BYTE_W-1:0]        data_byte,
    input  logic                               is_payload,
    input  logic [stid_pkg::WORD_W-1:0]        record_index,
    input  logic                               record_end,
    input  logic [stid_pkg::WORD_W-1:0]        records_done,
    input  logic [stid_pkg::STATUS_W-1:0]      status
);
    import stid_pkg::*;

    // An input item that is offered stays offered and unchanged until taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(image_byte)
            && $stable(last_byte))
        else $error("input item changed while waiting");

    // A result that is not taken stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte)
            && $stable(status) && $stable(records_done))
        else $error("output item changed while stalled");

    // A closed record is counted in records_done on the same item.
    a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_end |-> records_done == record_index + 32'd1)
        else $error("record_end without matching records_done");

    // Fault items carry no record labels.
    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD_MAGIC || status == ST_BAD_COUNT
            || status == ST_TRAIL)
        |-> !is_payload && !record_end && record_index == '0)
        else $error("fault item carries record labels");

    // A finished image that ends on a payload byte closes its record with it.
    a_valid_not_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_VALID && is_payload |-> record_end)
        else $error("valid image ended inside a record");

endmodule

bind string_table_image_deframer stid_checker u_stid_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the string-table image deframer.
module tb_top;

    import stid_pkg::*;

    // Random images per phase, counted in bytes, and the various waits in cycles.
    localparam int unsigned ITEMS_PER_PHASE = 290;
    localparam int unsigned DRAIN_GAP       = 4;
    localparam int unsigned LONG_STALL      = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    // Shapes of image that the stimulus builds.
    typedef enum int unsigned {
        IMG_GOOD,
        IMG_TRUNC,
        IMG_TRAIL,
        IMG_BAD_MAGIC,
        IMG_BAD_COUNT,
        IMG_SHORT,
        IMG_NOISE
    } image_kind_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [WORD_W-1:0]   cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   image_byte = '0;
    logic                last_byte  = 1'b0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [BYTE_W-1:0]   data_byte;
    logic                is_payload;
    logic [WORD_W-1:0]   record_index;
    logic                record_end;
    logic [WORD_W-1:0]   records_done;
    logic [STATUS_W-1:0] status;

    // Bytes waiting to be offered, and the labels predicted for bytes already taken.
    stid_in_item_t pending_bytes[$];
    stid_result_t  expected_labels[$];

    // Idle percentages for both sides, and the long output hold-off.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        rx_stalled    = 1'b0;
    event        long_stall_go;

    int unsigned mismatches     = 0;
    int unsigned labels_checked = 0;
    int unsigned magic_writes   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned endings [0:7]  = '{default: 0};

    // Predictor state: a copy of the magic register and of the parser.
    logic [WORD_W-1:0]   magic_cfg = MAGIC_RESET;
    logic [PHASE_W-1:0]  frame_phase;
    logic [POS_W-1:0]    pos_in_field;
    logic [WORD_W-1:0]   word_acc;
    logic                count_hi_seen;
    logic [WORD_W-1:0]   records_expected;
    logic [WORD_W-1:0]   records_closed;
    logic [WORD_W-1:0]   payload_remaining;
    logic [STATUS_W-1:0] fault_seen;

    string_table_image_deframer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .image_byte   (image_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .is_payload   (is_payload),
        .record_index (record_index),
        .record_end   (record_end),
        .records_done (records_done),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Returns the parser to the start of an image. The magic register is kept.
    function automatic void restart_frame();
        frame_phase       = PH_MAGIC;
        pos_in_field      = '0;
        word_acc          = '0;
        count_hi_seen     = 1'b0;
        records_expected  = '0;
        records_closed    = '0;
        payload_remaining = '0;
        fault_seen        = ST_RUN;
    endfunction

    // Works out the label of one accepted byte and advances the parser copy.
    function automatic stid_result_t label_byte(logic [BYTE_W-1:0] b, logic last);
        stid_result_t r;
        logic         closes;
        r           = '0;
        r.data_byte = b;
        closes      = 1'b0;

        // Magic and length bytes, and the low half of the count, are gathered
        // into a little-endian word. The upper half of the count is only
        // checked for being zero.
        if (frame_phase == PH_MAGIC || frame_phase == PH_LEN
            || (frame_phase == PH_COUNT && pos_in_field < 3'd4))
        begin
            word_acc     = word_acc | ({24'h0, b} << (8 * pos_in_field[1:0]));
            pos_in_field = pos_in_field + 1'b1;
        end
        else if (frame_phase == PH_COUNT)
        begin
            if (b != 8'h00)
                count_hi_seen = 1'b1;
            pos_in_field = pos_in_field + 1'b1;
        end

        case (frame_phase)
            PH_MAGIC:
            begin
                // A last byte inside the header wins over a wrong magic word.
                if (last)
                begin
                    fault_seen  = ST_TRUNC;
                    frame_phase = PH_FAULT;
                end
                else if (pos_in_field == 3'd4)
                begin
                    if (word_acc != magic_cfg)
                    begin
                        fault_seen  = ST_BAD_MAGIC;
                        frame_phase = PH_FAULT;
                    end
                    else
                    begin
                        frame_phase  = PH_COUNT;
                        pos_in_field = '0;
                        word_acc     = '0;
                    end
                end
            end
            PH_COUNT:
            begin
                // The position wraps to zero on the eighth count byte.
                if (pos_in_field == 3'd0)
                begin
                    if (count_hi_seen)
                    begin
                        fault_seen  = ST_BAD_COUNT;
                        frame_phase = PH_FAULT;
                    end
                    else
                    begin
                        records_expected = word_acc;
                        word_acc         = '0;
                        frame_phase      = (word_acc == records_expected) ? PH_DONE : PH_LEN;
                    end
                end
                else if (last)
                begin
                    fault_seen  = ST_TRUNC;
                    frame_phase = PH_FAULT;
                end
            end
            PH_LEN:
            begin
                r.record_index = records_closed;
                if (pos_in_field == 3'd4)
                begin
                    pos_in_field      = '0;
                    payload_remaining = word_acc;
                    word_acc          = '0;
                    // An empty record ends on its last length byte.
                    if (payload_remaining == '0)
                        closes = 1'b1;
                    else
                        frame_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                r.is_payload      = 1'b1;
                r.record_index    = records_closed;
                payload_remaining = payload_remaining - 1'b1;
                if (payload_remaining == '0)
                    closes = 1'b1;
            end
            PH_DONE:
            begin
                fault_seen  = ST_TRAIL;
                frame_phase = PH_FAULT;
            end
            default:
            begin
            end
        endcase

        if (closes)
        begin
            records_closed = records_closed + 1'b1;
            frame_phase    = (records_closed == records_expected) ? PH_DONE : PH_LEN;
            r.record_end   = 1'b1;
        end
        r.records_done = records_closed;

        // Once faulted, every byte up to the last carries the fault code and
        // no record labels.
        if (frame_phase == PH_FAULT)
        begin
            r.status       = fault_seen;
            r.is_payload   = 1'b0;
            r.record_index = '0;
            r.record_end   = 1'b0;
        end
        else if (last)
            r.status = (frame_phase == PH_DONE) ? ST_VALID : ST_TRUNC;
        else
            r.status = ST_RUN;

        if (last)
        begin
            endings[r.status] = endings[r.status] + 1;
            restart_frame();
        end
        return r;
    endfunction

    // Builds one image of the given shape against the current magic word.
    // Record lengths run from zero up to maxlen.
    function automatic byte_q_t make_image(image_kind_t kind, int unsigned nrec,
                                           int unsigned maxlen);
        byte_q_t           img;
        logic [WORD_W-1:0] word;
        logic [63:0]       count;
        logic [WORD_W-1:0] len;
        int unsigned       keep;
        int unsigned       sel;
        if (kind == IMG_NOISE)
        begin
            repeat ($urandom_range(1, 16))
                img.push_back(BYTE_W'($urandom_range(255)));
            return img;
        end
        if (kind == IMG_TRUNC && nrec == 0)
            nrec = 1;

        // A wrong magic word differs in at least one chosen bit.
        word = magic_cfg;
        if (kind == IMG_BAD_MAGIC)
            word = word ^ ((32'h1 << $urandom_range(31))
                           | ($urandom_range(1) ? $urandom() : 32'h0));
        for (int k = 0; k < 4; k++)
            img.push_back(word[8*k +: 8]);

        // A bad count has one of its upper four bytes nonzero.
        count = {32'h0, nrec};
        if (kind == IMG_BAD_COUNT)
        begin
            sel = $urandom_range(3);
            count[32 + 8*sel +: 8] = $urandom_range(1, 255);
        end
        for (int k = 0; k < 8; k++)
            img.push_back(count[8*k +: 8]);

        for (int r = 0; r < nrec; r++)
        begin
            len = $urandom_range(maxlen);
            for (int k = 0; k < 4; k++)
                img.push_back(len[8*k +: 8]);
            repeat (len)
                img.push_back(BYTE_W'($urandom_range(255)));
        end

        // Short headers stop inside the first twelve bytes; truncated images
        // stop anywhere after the header but before the last record is done.
        case (kind)
            IMG_SHORT: keep = $urandom_range(1, 11);
            IMG_TRUNC: keep = $urandom_range(12, img.size() - 1);
            default:   keep = img.size();
        endcase
        while (img.size() > keep)
            void'(img.pop_back());
        if (kind == IMG_TRAIL)
            repeat ($urandom_range(1, 3))
                img.push_back(BYTE_W'($urandom_range(255)));
        return img;
    endfunction

    // Queues an image for the driver, flagging its final byte.
    task automatic send_image(input byte_q_t img);
        for (int i = 0; i < img.size(); i++)
            pending_bytes.push_back('{image_byte: img[i], last_byte: (i == img.size() - 1)});
    endtask

    // Waits at falling edges until every queued byte is taken and labelled,
    // then lets the pipeline settle.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_labels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP)
            @(negedge clk);
    endtask

    // Writes the magic register; only called while no bytes are in flight.
    task automatic write_magic(input logic [WORD_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        magic_cfg    = value;
        magic_writes = magic_writes + 1;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Input driver. A byte taken at this edge is labelled right away; a free
    // slot is then refilled from the queue unless the sender idles this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        stid_in_item_t next_item;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            image_byte <= '0;
            last_byte  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_labels.push_back(label_byte(image_byte, last_byte));
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item  = pending_bytes.pop_front();
                    in_valid   <= 1'b1;
                    image_byte <= next_item.image_byte;
                    last_byte  <= next_item.last_byte;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: random stalls, plus the long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !rx_stalled && ($urandom_range(99) >= recv_idle_pct);
    end

    // The hold-off counts its own cycles so the sender keeps offering bytes
    // while the deframer fills up and drops in_ready.
    initial
    begin
        forever
        begin
            @(long_stall_go);
            rx_stalled = 1'b1;
            repeat (LONG_STALL)
                @(negedge clk);
            rx_stalled = 1'b0;
        end
    end

    // Output monitor: every accepted output item is compared with the oldest label.
    always @(posedge clk)
    begin
        stid_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_labels.size() == 0)
            begin
                $error("output item 0x%0h arrived with no byte outstanding", data_byte);
                mismatches = mismatches + 1;
            end
            else
            begin
                want           = expected_labels.pop_front();
                labels_checked = labels_checked + 1;
                check_field("data_byte", WORD_W'(want.data_byte), WORD_W'(data_byte));
                check_field("is_payload", WORD_W'(want.is_payload), WORD_W'(is_payload));
                check_field("record_index", want.record_index, record_index);
                check_field("record_end", WORD_W'(want.record_end), WORD_W'(record_end));
                check_field("records_done", want.records_done, records_done);
                check_field("status", WORD_W'(want.status), WORD_W'(status));
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d labels outstanding",
                         quiet_cycles, expected_labels.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus sequence. Five phases, each under a set magic word: the first
    // keeps the reset value, the others write zero, all ones, a random word and
    // the reset value again. The first two phases idle the sender lightly and
    // the receiver heavily, the next two the other way round, the last neither.
    initial
    begin
        byte_q_t     img;
        int unsigned cut;
        int unsigned roll;
        image_kind_t kind;

        restart_frame();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                1: write_magic('0);
                2: write_magic('1);
                3: write_magic($urandom());
                4: write_magic(MAGIC_RESET);
                default:
                begin
                end
            endcase
            send_idle_pct = (p < 2) ? 18 : (p < 4) ? 86 : 0;
            recv_idle_pct = (p < 2) ? 86 : (p < 4) ? 18 : 0;

            if (p == 0)
            begin
                // A single byte that is also the last: a header cut short.
                img.delete();
                img.push_back(8'hFF);
                send_image(img);
                // Zero records, so the image is complete after the header and
                // anything following it is trailing.
                send_image(make_image(IMG_TRAIL, 0, 0));
                send_image(make_image(IMG_BAD_MAGIC, 0, 0));
                send_image(make_image(IMG_BAD_COUNT, 0, 0));
                // The largest count, an empty first record, then a record that
                // claims the largest length and stops after two bytes.
                img = make_image(IMG_GOOD, 0, 0);
                for (int k = 4; k < 8; k++)
                    img[k] = 8'hFF;
                repeat (4)
                    img.push_back(8'h00);
                repeat (4)
                    img.push_back(8'hFF);
                img.push_back(8'h00);
                img.push_back(8'hFF);
                send_image(img);
                wait_drained();
            end

            if (p == 4)
            begin
                // Hold the output off while good images keep streaming in, so
                // both internal registers fill and the input stalls.
                -> long_stall_go;
                repeat (6)
                    send_image(make_image(IMG_GOOD, 3, 8));
                wait_drained();
                // Stop the sender in the middle of an image until every label
                // is back, then finish the image.
                img = make_image(IMG_GOOD, 4, 12);
                cut = img.size() / 2;
                for (int i = 0; i < img.size(); i++)
                begin
                    pending_bytes.push_back('{image_byte: img[i],
                                              last_byte: (i == img.size() - 1)});
                    if (i == cut)
                        wait_drained();
                end
            end

            // Random images, mostly well formed so the record phases get
            // exercised, the rest faulty in every way the format allows.
            while (pending_bytes.size() < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 55)
                    kind = IMG_GOOD;
                else if (roll < 65)
                    kind = IMG_TRUNC;
                else if (roll < 73)
                    kind = IMG_TRAIL;
                else if (roll < 81)
                    kind = IMG_BAD_MAGIC;
                else if (roll < 88)
                    kind = IMG_BAD_COUNT;
                else if (roll < 94)
                    kind = IMG_SHORT;
                else
                    kind = IMG_NOISE;
                send_image(make_image(kind,
                                      ($urandom_range(9) == 0) ? $urandom_range(5, 8)
                                                               : $urandom_range(4),
                                      ($urandom_range(7) == 0) ? 40 : 8));
            end
            wait_drained();
        end

        $display("Covered %0d labelled bytes over %0d images with %0d magic writes:",
                 labels_checked,
                 endings[ST_VALID] + endings[ST_BAD_MAGIC] + endings[ST_BAD_COUNT]
                 + endings[ST_TRUNC] + endings[ST_TRAIL],
                 magic_writes);
        $display("  %0d valid, %0d bad magic, %0d bad count, %0d truncated, %0d trailing.",
                 endings[ST_VALID], endings[ST_BAD_MAGIC], endings[ST_BAD_COUNT],
                 endings[ST_TRUNC], endings[ST_TRAIL]);
        if (mismatches == 0 && expected_labels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
